### design/ppu_pkg.sv
// ---------------------------------------------------------------------------
// ppu_pkg: shared types and helpers for the palette pixel upscaler
// Widths, register indexes, command codes and palette word forming.
// ---------------------------------------------------------------------------
package ppu_pkg;

	localparam int MAX_WIDTH  = 640;
	localparam int MAX_HEIGHT = 400;
	localparam int PAL_DEPTH  = 256;
	localparam int MAX_SCALE  = 4;

	localparam int IDX_W   = $clog2(PAL_DEPTH);
	localparam int LVL_W   = 8;
	localparam int WORD_W  = 32;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int SCL_W   = 3;
	localparam int STEP_W  = 2;
	localparam int ADDR_W  = 22;
	localparam int RBASE_W = ROW_W + STEP_W;   // row * scale
	localparam int CBASE_W = COL_W + STEP_W;   // col * scale, also line pitch

	typedef enum logic [2:0] {
		REG_SCALE      = 3'd0,
		REG_TRUE_COLOR = 3'd1,
		REG_RED_MASK   = 3'd2,
		REG_GREEN_MASK = 3'd3,
		REG_BLUE_MASK  = 3'd4,
		REG_SWAP       = 3'd5,
		REG_WIDTH      = 3'd6,
		REG_HEIGHT     = 3'd7
	} reg_idx_t;

	typedef enum logic [0:0] {
		CMD_PAL_WRITE = 1'b0,
		CMD_PIXEL     = 1'b1
	} cmd_t;

	// palette word forming controls
	typedef struct packed {
		logic [WORD_W-1:0] r_mask;
		logic [WORD_W-1:0] g_mask;
		logic [WORD_W-1:0] b_mask;
		logic              swap;
	} pal_cfg_t;

	// per-pixel job handed to the emitter at accept
	typedef struct packed {
		logic [RBASE_W-1:0] row_base;
		logic [CBASE_W-1:0] col_base;
		logic [CBASE_W-1:0] pitch;
		logic [STEP_W-1:0]  last_step;
	} pix_job_t;

	function automatic logic [WORD_W-1:0] spread_byte(input logic [LVL_W-1:0] b);
		return {8'h00, b, b, b};
	endfunction

	function automatic logic [WORD_W-1:0] reverse_bytes(input logic [WORD_W-1:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic logic [SCL_W-1:0] eff_scale(input logic [SCL_W-1:0] s);
		logic [SCL_W-1:0] r;
		r = s;
		if (s == '0)
			r = SCL_W'(1);
		else if (s > SCL_W'(MAX_SCALE))
			r = SCL_W'(MAX_SCALE);
		return r;
	endfunction

	function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] w);
		logic [COL_W-1:0] r;
		r = w;
		if (w == '0)
			r = COL_W'(1);
		else if (w > COL_W'(MAX_WIDTH))
			r = COL_W'(MAX_WIDTH);
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] h);
		logic [ROW_W-1:0] r;
		r = h;
		if (h == '0)
			r = ROW_W'(1);
		else if (h > ROW_W'(MAX_HEIGHT))
			r = ROW_W'(MAX_HEIGHT);
		return r;
	endfunction

endpackage

### design/ppu_palette.sv
// ---------------------------------------------------------------------------
// ppu_palette: palette store with registered lookup
// Forms and writes palette words; reads one entry per pixel into a register.
// ---------------------------------------------------------------------------
module ppu_palette (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ppu_pkg::pal_cfg_t          pal_cfg,
	input  logic                       wr_en,
	input  logic [ppu_pkg::IDX_W-1:0]  wr_idx,
	input  logic [ppu_pkg::LVL_W-1:0]  red_level,
	input  logic [ppu_pkg::LVL_W-1:0]  green_level,
	input  logic [ppu_pkg::LVL_W-1:0]  blue_level,
	input  logic                       rd_en,
	input  logic [ppu_pkg::IDX_W-1:0]  rd_idx,
	input  logic                       true_color,
	output logic [ppu_pkg::WORD_W-1:0] pixel_word
);
	import ppu_pkg::*;

	logic [WORD_W-1:0]    mem [PAL_DEPTH];
	logic [PAL_DEPTH-1:0] written_q;
	logic [WORD_W-1:0]    wr_word;
	logic [WORD_W-1:0]    rd_word_s1;
	logic                 rd_hit_s1;
	logic                 tc_s1;
	logic [IDX_W-1:0]     idx_s1;

	always_comb begin
		wr_word = (spread_byte(red_level)   & pal_cfg.r_mask) |
		          (spread_byte(green_level) & pal_cfg.g_mask) |
		          (spread_byte(blue_level)  & pal_cfg.b_mask);
		if (pal_cfg.swap)
			wr_word = reverse_bytes(wr_word);
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_word;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_s1 <= mem[rd_idx];
			tc_s1      <= true_color;
			idx_s1     <= rd_idx;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_hit_s1 <= 1'b0;
		end else begin
			if (wr_en)
				written_q[wr_idx] <= 1'b1;
			if (rd_en)
				rd_hit_s1 <= written_q[rd_idx];
		end
	end

	always_comb begin
		if (!tc_s1)
			pixel_word = {{(WORD_W-IDX_W){1'b0}}, idx_s1};
		else if (rd_hit_s1)
			pixel_word = rd_word_s1;
		else
			pixel_word = '0;
	end

endmodule

### design/ppu_emitter.sv
// ---------------------------------------------------------------------------
// ppu_emitter: copy sequencer and result register
// Walks the scale x scale block of one pixel and forms each address.
// ---------------------------------------------------------------------------
module ppu_emitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  ppu_pkg::pix_job_t           job,
	input  logic [ppu_pkg::WORD_W-1:0]  pixel_word,
	output logic                        ready,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [ppu_pkg::ADDR_W-1:0]  dest_address,
	output logic [ppu_pkg::WORD_W-1:0]  pixel_value,
	output logic                        last_copy
);
	import ppu_pkg::*;

	pix_job_t               job_s1;
	logic                   busy_s1;
	logic [STEP_W-1:0]      dy_q;
	logic [STEP_W-1:0]      dx_q;
	logic                   res_valid_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [WORD_W-1:0]      value_q;
	logic                   last_q;

	logic                   advance;
	logic                   at_last;
	logic                   done;
	logic [RBASE_W-1:0]     y;
	logic [CBASE_W-1:0]     x;
	logic [RBASE_W+CBASE_W-1:0] prod;
	logic [ADDR_W-1:0]      addr_d;

	assign advance = busy_s1 && (!res_valid_q || !result_stall);
	assign at_last = (dy_q == job_s1.last_step) && (dx_q == job_s1.last_step);
	assign done    = advance && at_last;
	assign ready   = !busy_s1 || done;

	always_comb begin
		y      = job_s1.row_base + RBASE_W'(dy_q);
		x      = job_s1.col_base + CBASE_W'(dx_q);
		prod   = {{CBASE_W{1'b0}}, y} * {{RBASE_W{1'b0}}, job_s1.pitch};
		addr_d = prod[ADDR_W-1:0] + ADDR_W'(x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			dy_q    <= '0;
			dx_q    <= '0;
		end else if (load) begin
			busy_s1 <= 1'b1;
			dy_q    <= '0;
			dx_q    <= '0;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end else if (advance) begin
			if (dx_q == job_s1.last_step) begin
				dx_q <= '0;
				dy_q <= dy_q + 1'b1;
			end else begin
				dx_q <= dx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			job_s1 <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			addr_q  <= addr_d;
			value_q <= pixel_word;
			last_q  <= at_last;
		end
	end

	assign result_valid = res_valid_q;
	assign dest_address = addr_q;
	assign pixel_value  = value_q;
	assign last_copy    = last_q;

	a_load_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ready)
		else $error("pixel loaded while a block is still being emitted");

	a_steps_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> (dy_q <= job_s1.last_step) && (dx_q <= job_s1.last_step))
		else $error("copy counters left the scaled block");

	a_final_marked: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> result_valid && last_copy)
		else $error("final copy not marked in the result register");

endmodule

### design/palette_pixel_upscaler_unit.sv
// ---------------------------------------------------------------------------
// palette_pixel_upscaler_unit: indexed color lookup with integer upscaling
// Palette writes fill a 256-entry store; source pixels are looked up and
// replicated scale x scale times with their destination addresses.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------
//   item     | item_valid / item_stall | command, color_index, *_level
//   result   | result_valid/result_stall| dest_address, pixel_value, last_copy
//   cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A palette write yields nothing. A pixel yields S*S copies (1 to 16), one
// copy per cycle out of the result register unless result_stall holds it;
// the first copy is formed from the palette read and job registers loaded
// at the transfer in. The emitter's single result register sets that rate.
// The next pixel is taken in the cycle its predecessor's last copy enters
// the result register. Reset clears all palette valid bits at once (entries
// read as zero until written), so no clearing pass is needed.
// ---------------------------------------------------------------------------
module palette_pixel_upscaler_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [ppu_pkg::WORD_W-1:0]  cfg_data,
	// input items
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        command,
	input  logic [ppu_pkg::IDX_W-1:0]   color_index,
	input  logic [ppu_pkg::LVL_W-1:0]   red_level,
	input  logic [ppu_pkg::LVL_W-1:0]   green_level,
	input  logic [ppu_pkg::LVL_W-1:0]   blue_level,
	// results
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [ppu_pkg::ADDR_W-1:0]  dest_address,
	output logic [ppu_pkg::WORD_W-1:0]  pixel_value,
	output logic                        last_copy
);
	import ppu_pkg::*;

	// configuration registers
	logic [SCL_W-1:0]  scale_q;
	logic              true_color_q;
	pal_cfg_t          pal_cfg_q;
	logic [COL_W-1:0]  width_q;
	logic [ROW_W-1:0]  height_q;

	// raster position of the next source pixel
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic              cfg_wr;
	logic              is_pixel;
	logic              item_xfer;
	logic              pixel_xfer;
	logic              pal_xfer;
	logic              emit_ready;
	logic [SCL_W-1:0]  s_eff;
	logic [COL_W-1:0]  w_eff;
	logic [ROW_W-1:0]  h_eff;
	pix_job_t          job;

	// the port never back-pressures a write
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q          <= SCL_W'(1);
			true_color_q     <= 1'b1;
			pal_cfg_q.r_mask <= 32'h00FF_0000;
			pal_cfg_q.g_mask <= 32'h0000_FF00;
			pal_cfg_q.b_mask <= 32'h0000_00FF;
			pal_cfg_q.swap   <= 1'b0;
			width_q          <= COL_W'(320);
			height_q         <= ROW_W'(200);
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_SCALE:      scale_q          <= cfg_data[SCL_W-1:0];
				REG_TRUE_COLOR: true_color_q     <= cfg_data[0];
				REG_RED_MASK:   pal_cfg_q.r_mask <= cfg_data;
				REG_GREEN_MASK: pal_cfg_q.g_mask <= cfg_data;
				REG_BLUE_MASK:  pal_cfg_q.b_mask <= cfg_data;
				REG_SWAP:       pal_cfg_q.swap   <= cfg_data[0];
				REG_WIDTH:      width_q          <= cfg_data[COL_W-1:0];
				REG_HEIGHT:     height_q         <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold a pixel while the emitter is still busy; palette writes always pass.
	assign is_pixel   = (command == CMD_PIXEL);
	assign item_stall = is_pixel && !emit_ready;
	assign item_xfer  = item_valid && !item_stall;
	assign pixel_xfer = item_xfer && is_pixel;
	assign pal_xfer   = item_xfer && !is_pixel;

	// clamp out-of-range settings
	assign s_eff = eff_scale(scale_q);
	assign w_eff = eff_width(width_q);
	assign h_eff = eff_height(height_q);

	// block origin and line pitch of the scaled frame
	always_comb begin
		job.row_base  = RBASE_W'({{STEP_W{1'b0}}, row_q} * {{(RBASE_W-SCL_W){1'b0}}, s_eff});
		job.col_base  = CBASE_W'({{STEP_W{1'b0}}, col_q} * {{(CBASE_W-SCL_W){1'b0}}, s_eff});
		job.pitch     = CBASE_W'({{STEP_W{1'b0}}, w_eff} * {{(CBASE_W-SCL_W){1'b0}}, s_eff});
		job.last_step = STEP_W'(s_eff - SCL_W'(1));
	end

	// Advance the raster position per pixel; wrap at line and frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pixel_xfer) begin
			if ({1'b0, col_q} + 1'b1 >= {1'b0, w_eff}) begin
				col_q <= '0;
				if ({1'b0, row_q} + 1'b1 >= {1'b0, h_eff})
					row_q <= '0;
				else
					row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	logic [WORD_W-1:0] pixel_word;

	ppu_palette u_palette (
		.clk         (clk),
		.arst_n      (arst_n),
		.pal_cfg     (pal_cfg_q),
		.wr_en       (pal_xfer),
		.wr_idx      (color_index),
		.red_level   (red_level),
		.green_level (green_level),
		.blue_level  (blue_level),
		.rd_en       (pixel_xfer),
		.rd_idx      (color_index),
		.true_color  (true_color_q),
		.pixel_word  (pixel_word)
	);

	ppu_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (pixel_xfer),
		.job          (job),
		.pixel_word   (pixel_word),
		.ready        (emit_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.dest_address (dest_address),
		.pixel_value  (pixel_value),
		.last_copy    (last_copy)
	);

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < COL_W'(MAX_WIDTH))
		else $error("column count past the widest line");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < ROW_W'(MAX_HEIGHT))
		else $error("row count past the tallest frame");

endmodule
